/* rtl/utf8pp_pkg.sv */
// ============================================================================
// utf8pp_pkg
// Shared types, constants and helpers for the UTF-8 punctuation peeling
// tokenizer.
// ============================================================================
package utf8pp_pkg;

    localparam int MAX_BYTES = 65536;
    localparam int CNT_W     = 16;
    localparam int CP_W      = 21;
    localparam int UNIT_N_W  = 3;
    localparam int EXP_W     = 3;
    localparam int COL_W     = 2;

    localparam logic [CNT_W-1:0] CAP =
        CNT_W'((MAX_BYTES > 65536) ? 65535 : MAX_BYTES - 1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_TAB   = 8'h09;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;

    localparam logic [7:0] MASK_1 = 8'h80;
    localparam logic [7:0] MASK_2 = 8'hE0;
    localparam logic [7:0] MASK_3 = 8'hF0;
    localparam logic [7:0] MASK_4 = 8'hF8;
    localparam logic [7:0] LEAD_2 = 8'hC0;
    localparam logic [7:0] LEAD_3 = 8'hE0;
    localparam logic [7:0] LEAD_4 = 8'hF0;

    localparam logic [EXP_W-1:0] SEQ_NONE = 3'd0;
    localparam logic [EXP_W-1:0] SEQ_TWO  = 3'd2;
    localparam logic [EXP_W-1:0] SEQ_THREE = 3'd3;
    localparam logic [EXP_W-1:0] SEQ_FOUR = 3'd4;

    typedef enum logic [1:0] {
        PH_BETWEEN,
        PH_LEAD,
        PH_BODY
    } phase_t;

    // One decoded unit (or a non-punctuation unit merged with the one after it).
    // trail set: add n to the trailing run; clear: run becomes tset.
    typedef struct packed {
        logic [UNIT_N_W-1:0] n;
        logic                lead;
        logic                trail;
        logic                tset;
    } unit_t;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] start_pos;
        unit_t            unit;
        logic             close;
        logic             last;
        logic             pos_ovf;
    } op_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    function automatic logic is_lead_cp(logic [CP_W-1:0] cp);
        return cp inside {21'h28, 21'h5B, 21'h7B, 21'h22, 21'h27, 21'h201C, 21'h2018};
    endfunction

    function automatic logic is_trail_cp(logic [CP_W-1:0] cp);
        return cp inside {21'h2E, 21'h2C, 21'h3B, 21'h3A, 21'h21, 21'h3F, 21'h29,
                          21'h5D, 21'h7D, 21'h22, 21'h27, 21'h201D, 21'h2019,
                          21'h2014, 21'h2026};
    endfunction

    // {overflow, saturated sum}
    function automatic logic [CNT_W:0] sat_add(logic [CNT_W-1:0] x,
                                               logic [UNIT_N_W-1:0] n);
        logic [CNT_W:0] s;
        s = {1'b0, x} + {{(CNT_W + 1 - UNIT_N_W){1'b0}}, n};
        if (s > {1'b0, CAP})
        begin
            return {1'b1, CAP};
        end
        return {1'b0, s[CNT_W-1:0]};
    endfunction

endpackage

/* rtl/utf8pp_in_if.sv */
// ============================================================================
// utf8pp_in_if
// Byte stream channel: valid/ready handshake with one sentence byte per beat.
// ============================================================================
interface utf8pp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

/* rtl/utf8pp_out_if.sv */
// ============================================================================
// utf8pp_out_if
// Token result channel: valid/ready handshake with one chunk report per beat.
// ============================================================================
interface utf8pp_out_if;
    import utf8pp_pkg::*;

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] chunk_offset;
    logic [CNT_W-1:0] lead_len;
    logic [CNT_W-1:0] word_len;
    logic [CNT_W-1:0] trail_len;
    logic             has_word;
    logic             sentence_end;
    logic             overflow;

    modport source (output valid, output chunk_offset, output lead_len, output word_len,
                    output trail_len, output has_word, output sentence_end,
                    output overflow, input ready);
    modport sink   (input valid, input chunk_offset, input lead_len, input word_len,
                    input trail_len, input has_word, input sentence_end,
                    input overflow, output ready);
endinterface

/* rtl/utf8_punct_peeling_tokenizer_core.sv */
// The block takes one sentence byte per beat and sustains one byte per
// clock cycle while the queue has room. Each accepted byte is decoded and
// classified into a two-entry queue; the back end consumes one entry per
// cycle into the output register unless a waiting result holds it. The
// closing byte's entry is registered in the queue, then its result in the
// output register. The output register sets the rate under back pressure:
// the queue fills and the byte channel stalls only while a result waits.
// ============================================================================
// utf8_punct_peeling_tokenizer_core
// UTF-8 whitespace chunker with leading/trailing punctuation peeling.
// ============================================================================
module utf8_punct_peeling_tokenizer_core (
    input  logic          clk,
    input  logic          rst_n,
    utf8pp_in_if.sink     data,
    utf8pp_out_if.source  token
);
    import utf8pp_pkg::*;

    logic   push;
    logic   pop;
    op_t    wr_op;
    op_t    rd_op;
    qstat_t q_stat;

    utf8pp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .data   (data),
        .q_stat (q_stat),
        .push   (push),
        .op     (wr_op)
    );

    utf8pp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_op  (wr_op),
        .pop    (pop),
        .rd_op  (rd_op),
        .q_stat (q_stat)
    );

    utf8pp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (rd_op),
        .q_stat (q_stat),
        .pop    (pop),
        .token  (token)
    );

    a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue both empty and full");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("push into full queue");

    a_no_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (token.valid && !token.has_word) |->
            (token.chunk_offset == '0 && token.lead_len == '0 &&
             token.word_len == '0 && token.trail_len == '0 && token.sentence_end))
        else $error("wordless result not cleared");

    a_word_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (token.valid && token.has_word) |-> token.word_len != '0)
        else $error("word result with empty word");

endmodule

/* rtl/utf8pp_front.sv */
// ============================================================================
// utf8pp_front
// Accepts sentence bytes, splits on whitespace, decodes UTF-8 and classifies
// each byte's units into one queue entry.
// ============================================================================
module utf8pp_front (
    input  logic                 clk,
    input  logic                 rst_n,
    utf8pp_in_if.sink            data,
    input  utf8pp_pkg::qstat_t   q_stat,
    output logic                 push,
    output utf8pp_pkg::op_t      op
);
    import utf8pp_pkg::*;

    logic [EXP_W-1:0] exp_reg,  exp_next;
    logic [COL_W-1:0] col_reg,  col_next;
    logic [CP_W-1:0]  part_reg, part_next;
    logic [CNT_W-1:0] pos_reg,  pos_next;
    logic             open_reg, open_next;
    logic             ovf_reg,  ovf_next;

    logic             ws;
    logic [7:0]       b;
    logic [COL_W-1:0] col1;
    logic [CP_W-1:0]  cp;
    logic [CNT_W:0]   pos_sum;
    unit_t            ua;
    unit_t            ub;
    unit_t            uf;

    assign data.ready = !q_stat.full;
    assign push       = data.valid && !q_stat.full;
    assign b          = data.data_byte;
    assign ws         = b inside {BYTE_SPACE, BYTE_TAB, BYTE_LF, BYTE_CR};
    assign col1       = col_reg + 2'd1;
    assign cp         = {part_reg[CP_W-7:0], b[5:0]};
    assign pos_sum    = sat_add(pos_reg, UNIT_N_W'(1));

    always_comb
    begin
        exp_next  = exp_reg;
        col_next  = col_reg;
        part_next = part_reg;
        open_next = open_reg;
        ua        = '0;
        ub        = '0;
        uf        = '0;
        op        = '0;
        op.last    = data.last_byte;
        op.pos_ovf = ovf_reg;
        op.start_pos = pos_reg;

        if (ws)
        begin
            if (open_reg)
            begin
                op.close = 1'b1;
                if (exp_reg != SEQ_NONE)
                begin
                    ua.n = {1'b0, col_reg} + 3'd1;
                end
                exp_next  = SEQ_NONE;
                col_next  = '0;
                part_next = '0;
                open_next = 1'b0;
            end
        end
        else
        begin
            if (!open_reg)
            begin
                op.start  = 1'b1;
                open_next = 1'b1;
            end
            if (exp_reg != SEQ_NONE && b[7:6] == 2'b10)
            begin
                if (({1'b0, col1} + 3'd1) >= exp_reg)
                begin
                    ua.n      = exp_reg;
                    ua.lead   = is_lead_cp(cp);
                    ua.trail  = is_trail_cp(cp);
                    exp_next  = SEQ_NONE;
                    col_next  = '0;
                    part_next = '0;
                end
                else
                begin
                    col_next  = col1;
                    part_next = cp;
                end
            end
            else
            begin
                if (exp_reg != SEQ_NONE)
                begin
                    ua.n = {1'b0, col_reg} + 3'd1;
                end
                exp_next  = SEQ_NONE;
                col_next  = '0;
                part_next = '0;
                if ((b & MASK_1) == 8'h00)
                begin
                    ub.n     = 3'd1;
                    ub.lead  = is_lead_cp({13'd0, b});
                    ub.trail = is_trail_cp({13'd0, b});
                end
                else if ((b & MASK_2) == LEAD_2)
                begin
                    exp_next  = SEQ_TWO;
                    part_next = {16'd0, b[4:0]};
                end
                else if ((b & MASK_3) == LEAD_3)
                begin
                    exp_next  = SEQ_THREE;
                    part_next = {17'd0, b[3:0]};
                end
                else if ((b & MASK_4) == LEAD_4)
                begin
                    exp_next  = SEQ_FOUR;
                    part_next = {18'd0, b[2:0]};
                end
                else
                begin
                    ub.n = 3'd1;
                end
            end
        end

        if (data.last_byte)
        begin
            op.close = 1'b1;
            if (exp_next != SEQ_NONE)
            begin
                uf.n = {1'b0, col_next} + 3'd1;
                if (ua.n == '0)
                begin
                    ua = uf;
                end
                else
                begin
                    ub = uf;
                end
            end
            exp_next  = SEQ_NONE;
            col_next  = '0;
            part_next = '0;
            open_next = 1'b0;
        end

        // A broken sequence never counts as punctuation, so it folds into what follows.
        if (ub.n != '0)
        begin
            if (ua.n != '0)
            begin
                op.unit.n     = ua.n + ub.n;
                op.unit.lead  = 1'b0;
                op.unit.trail = 1'b0;
                op.unit.tset  = ub.trail;
            end
            else
            begin
                op.unit = ub;
            end
        end
        else
        begin
            op.unit = ua;
        end
    end

    always_comb
    begin
        if (data.last_byte)
        begin
            pos_next = '0;
            ovf_next = 1'b0;
        end
        else
        begin
            pos_next = pos_sum[CNT_W-1:0];
            ovf_next = ovf_reg | pos_sum[CNT_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg  <= SEQ_NONE;
            col_reg  <= '0;
            part_reg <= '0;
            pos_reg  <= '0;
            open_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else if (push)
        begin
            exp_reg  <= exp_next;
            col_reg  <= col_next;
            part_reg <= part_next;
            pos_reg  <= pos_next;
            open_reg <= open_next;
            ovf_reg  <= ovf_next;
        end
    end

endmodule

/* rtl/utf8pp_queue.sv */
// ============================================================================
// utf8pp_queue
// Short FIFO of classified byte entries between front and back.
// ============================================================================
module utf8pp_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  utf8pp_pkg::op_t      wr_op,
    input  logic                 pop,
    output utf8pp_pkg::op_t      rd_op,
    output utf8pp_pkg::qstat_t   q_stat
);
    import utf8pp_pkg::*;

    op_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg,    cnt_next;

    assign rd_op        = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == QCNT_W'(QDEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

/* rtl/utf8pp_back.sv */
// ============================================================================
// utf8pp_back
// Applies queued units to the chunk counters, peels punctuation runs and
// registers a result for each closed chunk with a word and at sentence end.
// ============================================================================
module utf8pp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf8pp_pkg::op_t      op,
    input  utf8pp_pkg::qstat_t   q_stat,
    output logic                 pop,
    utf8pp_out_if.source         token
);
    import utf8pp_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] lead_reg,  lead_next;
    logic [CNT_W-1:0] body_reg,  body_next;
    logic [CNT_W-1:0] trail_reg, trail_next;
    logic             sat_reg,   sat_next;

    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] o_start_reg, o_start_next;
    logic [CNT_W-1:0] o_lead_reg,  o_lead_next;
    logic [CNT_W-1:0] o_word_reg,  o_word_next;
    logic [CNT_W-1:0] o_trail_reg, o_trail_next;
    logic             o_has_reg,   o_has_next;
    logic             o_end_reg,   o_end_next;
    logic             o_ovf_reg,   o_ovf_next;

    logic [CNT_W:0]   sa;
    logic [CNT_W:0]   sb;
    logic [CNT_W-1:0] word;
    logic             has;

    assign pop = !q_stat.empty && (!out_valid_reg || token.ready);

    assign token.valid        = out_valid_reg;
    assign token.chunk_offset = o_start_reg;
    assign token.lead_len     = o_lead_reg;
    assign token.word_len     = o_word_reg;
    assign token.trail_len    = o_trail_reg;
    assign token.has_word     = o_has_reg;
    assign token.sentence_end = o_end_reg;
    assign token.overflow     = o_ovf_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        start_next     = start_reg;
        lead_next      = lead_reg;
        body_next      = body_reg;
        trail_next     = trail_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !token.ready;
        o_start_next   = o_start_reg;
        o_lead_next    = o_lead_reg;
        o_word_next    = o_word_reg;
        o_trail_next   = o_trail_reg;
        o_has_next     = o_has_reg;
        o_end_next     = o_end_reg;
        o_ovf_next     = o_ovf_reg;
        sa             = '0;
        sb             = '0;
        word           = '0;
        has            = 1'b0;

        if (pop)
        begin
            if (op.start)
            begin
                phase_next = PH_LEAD;
                start_next = op.start_pos;
                lead_next  = '0;
                body_next  = '0;
                trail_next = '0;
            end

            if (op.unit.n != '0)
            begin
                if (phase_next == PH_LEAD && op.unit.lead)
                begin
                    sa        = sat_add(lead_next, op.unit.n);
                    lead_next = sa[CNT_W-1:0];
                    sat_next  = sat_next | sa[CNT_W];
                end
                else
                begin
                    if (phase_next == PH_LEAD)
                    begin
                        phase_next = PH_BODY;
                    end
                    sa        = sat_add(body_next, op.unit.n);
                    body_next = sa[CNT_W-1:0];
                    if (op.unit.trail)
                    begin
                        sb         = sat_add(trail_next, op.unit.n);
                        trail_next = sb[CNT_W-1:0];
                    end
                    else
                    begin
                        trail_next = {{(CNT_W - 1){1'b0}}, op.unit.tset};
                    end
                    sat_next = sat_next | sa[CNT_W] | (op.unit.trail & sb[CNT_W]);
                end
            end

            word = (body_next > trail_next) ? body_next - trail_next : '0;
            has  = (phase_next != PH_BETWEEN) && (word != '0);

            if (op.close && (has || op.last))
            begin
                out_valid_next = 1'b1;
                o_start_next   = has ? start_next : '0;
                o_lead_next    = has ? lead_next  : '0;
                o_word_next    = has ? word       : '0;
                o_trail_next   = has ? trail_next : '0;
                o_has_next     = has;
                o_end_next     = op.last;
                o_ovf_next     = sat_next | op.pos_ovf;
            end

            if (op.close)
            begin
                phase_next = PH_BETWEEN;
                lead_next  = '0;
                body_next  = '0;
                trail_next = '0;
            end
            if (op.last)
            begin
                sat_next   = 1'b0;
                start_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_BETWEEN;
            start_reg     <= '0;
            lead_reg      <= '0;
            body_reg      <= '0;
            trail_reg     <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            start_reg     <= start_next;
            lead_reg      <= lead_next;
            body_reg      <= body_next;
            trail_reg     <= trail_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_start_reg <= o_start_next;
        o_lead_reg  <= o_lead_next;
        o_word_reg  <= o_word_next;
        o_trail_reg <= o_trail_next;
        o_has_reg   <= o_has_next;
        o_end_reg   <= o_end_next;
        o_ovf_reg   <= o_ovf_next;
    end

endmodule
